FILE: sv/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 32;
	localparam int IN_FRAC  = 12;
	localparam int OUT_FRAC = 16;

	localparam int PROD_W = 2 * IN_W;
	localparam int COF_W  = 2 * IN_W + 1;
	localparam int TERM_W = COF_W + IN_W;
	localparam int DET_W  = 3 * IN_W + 2;

	typedef struct packed {
		logic signed [IN_W-1:0] a00;
		logic signed [IN_W-1:0] a01;
		logic signed [IN_W-1:0] a02;
		logic signed [IN_W-1:0] a10;
		logic signed [IN_W-1:0] a11;
		logic signed [IN_W-1:0] a12;
		logic signed [IN_W-1:0] a20;
		logic signed [IN_W-1:0] a21;
		logic signed [IN_W-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] inv00;
		logic signed [OUT_W-1:0] inv01;
		logic signed [OUT_W-1:0] inv02;
		logic signed [OUT_W-1:0] inv10;
		logic signed [OUT_W-1:0] inv11;
		logic signed [OUT_W-1:0] inv12;
		logic signed [OUT_W-1:0] inv20;
		logic signed [OUT_W-1:0] inv21;
		logic signed [OUT_W-1:0] inv22;
		logic                    singular;
		logic                    saturated;
	} inv_t;

endpackage

`default_nettype wire

FILE: sv/mi3_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mi3_div #(
	parameter int SHIFT = mi3_pkg::IN_FRAC + mi3_pkg::OUT_FRAC
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [mi3_pkg::COF_W-1:0]  cof,
	input  wire logic        [mi3_pkg::DET_W-1:0]  dmag,
	input  wire logic                              dneg,
	output logic signed      [mi3_pkg::OUT_W-1:0]  res,
	output logic                                   sat
);

	localparam int COF_W = mi3_pkg::COF_W;
	localparam int DW    = mi3_pkg::DET_W;
	localparam int OW    = mi3_pkg::OUT_W;
	localparam int NW    = COF_W + SHIFT;
	localparam int DS    = DW + OW + 1;
	localparam int CW    = ((NW > DS) ? NW : DS) + 1;
	localparam int L     = OW + 1;

	logic [COF_W-1:0] nmag_s1;
	logic             neg_s1;
	logic [DW-1:0]    d_s1;

	logic [CW-1:0]    rem_sd [0:L];
	logic [OW:0]      q_sd   [0:L];
	logic [DW-1:0]    d_sd   [0:L];
	logic             neg_sd [0:L];
	logic             ovr_sd [0:L];

	logic [OW+1:0]    qr_s4;
	logic             neg_s4;
	logic             ovr_s4;

	logic [CW-1:0]    num;
	logic             rnd;
	logic [OW+1:0]    lim;
	logic             sat_n;
	logic             sat_p;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
			neg_s1  <= cof[COF_W-1] ^ dneg;
			d_s1    <= dmag;
		end
	end

	assign num = CW'(nmag_s1) << SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= num;
			q_sd[0]   <= '0;
			d_sd[0]   <= d_s1;
			neg_sd[0] <= neg_s1;
			ovr_sd[0] <= num >= (CW'(d_s1) << (OW + 1));
		end
	end

	for (genvar j = 0; j < L; j++) begin : g_bit
		localparam int K = OW - j;
		logic [CW:0] diff;
		assign diff = {1'b0, rem_sd[j]} - {1'b0, (CW'(d_sd[j]) << K)};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j+1] <= diff[CW] ? rem_sd[j] : diff[CW-1:0];
				q_sd[j+1]   <= {q_sd[j][OW-1:0], ~diff[CW]};
				d_sd[j+1]   <= d_sd[j];
				neg_sd[j+1] <= neg_sd[j];
				ovr_sd[j+1] <= ovr_sd[j];
			end
		end
	end

	// round half away from zero on the magnitude
	assign rnd = {rem_sd[L], 1'b0} >= (CW + 1)'(d_sd[L]);

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s4  <= (OW + 2)'(q_sd[L]) + (OW + 2)'(rnd);
			neg_s4 <= neg_sd[L];
			ovr_s4 <= ovr_sd[L];
		end
	end

	assign lim   = (OW + 2)'(1) << (OW - 1);
	assign sat_n = ovr_s4 | (qr_s4 > lim);
	assign sat_p = ovr_s4 | (qr_s4 >= lim);

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s4) begin
				sat <= sat_n;
				res <= sat_n ? {1'b1, {(OW-1){1'b0}}} : -qr_s4[OW-1:0];
			end else begin
				sat <= sat_p;
				res <= sat_p ? {1'b0, {(OW-1){1'b1}}} : qr_s4[OW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/matrix_inverse_3x3.sv
// throughput: one matrix per cycle; the whole pipe advances unless the output word is stalled
// each of the nine elements runs through its own restoring divider, one quotient bit a stage
// reset clears the valid bits only; payload registers hold whatever they held
`timescale 1ns / 1ps
`default_nettype none

module matrix_inverse_3x3 #(
	parameter int IN_FRAC  = mi3_pkg::IN_FRAC,
	parameter int OUT_FRAC = mi3_pkg::OUT_FRAC
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          mat_valid,
	output logic               mat_stall,
	input  wire mi3_pkg::mat_t mat,
	output logic               inv_valid,
	input  wire logic          inv_stall,
	output mi3_pkg::inv_t      inv
);

	localparam int IN_W   = mi3_pkg::IN_W;
	localparam int PROD_W = mi3_pkg::PROD_W;
	localparam int COF_W  = mi3_pkg::COF_W;
	localparam int TERM_W = mi3_pkg::TERM_W;
	localparam int DET_W  = mi3_pkg::DET_W;
	localparam int OUT_W  = mi3_pkg::OUT_W;
	localparam int LAT    = OUT_W + 10;
	localparam int SING_D = LAT - 5;

	logic en;
	logic vld_q [0:LAT-1];

	logic signed [PROD_W-1:0] pp_s1 [0:17];
	logic signed [IN_W-1:0]   c2_s1 [0:2];
	logic signed [COF_W-1:0]  cof_s2 [0:8];
	logic signed [IN_W-1:0]   c2_s2 [0:2];
	logic signed [COF_W-1:0]  cof_s3 [0:8];
	logic signed [TERM_W-1:0] trm_s3 [0:2];
	logic signed [COF_W-1:0]  cof_s4 [0:8];
	logic signed [DET_W-1:0]  det_s4;
	logic signed [COF_W-1:0]  cof_s5 [0:8];
	logic        [DET_W-1:0]  dmag_s5;
	logic                     dneg_s5;
	logic                     sing_q [0:SING_D];

	logic signed [OUT_W-1:0]  res [0:8];
	logic        [8:0]        sat;
	logic                     sing;

	assign en        = ~vld_q[LAT-1] | ~inv_stall;
	assign mat_stall = ~en;
	assign inv_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= mat_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// products for the cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0]  <= mat.a11 * mat.a22;
			pp_s1[1]  <= mat.a21 * mat.a12;
			pp_s1[2]  <= mat.a21 * mat.a02;
			pp_s1[3]  <= mat.a01 * mat.a22;
			pp_s1[4]  <= mat.a01 * mat.a12;
			pp_s1[5]  <= mat.a11 * mat.a02;
			pp_s1[6]  <= mat.a12 * mat.a20;
			pp_s1[7]  <= mat.a22 * mat.a10;
			pp_s1[8]  <= mat.a22 * mat.a00;
			pp_s1[9]  <= mat.a02 * mat.a20;
			pp_s1[10] <= mat.a02 * mat.a10;
			pp_s1[11] <= mat.a12 * mat.a00;
			pp_s1[12] <= mat.a10 * mat.a21;
			pp_s1[13] <= mat.a20 * mat.a11;
			pp_s1[14] <= mat.a20 * mat.a01;
			pp_s1[15] <= mat.a00 * mat.a21;
			pp_s1[16] <= mat.a00 * mat.a11;
			pp_s1[17] <= mat.a10 * mat.a01;
			c2_s1[0]  <= mat.a02;
			c2_s1[1]  <= mat.a12;
			c2_s1[2]  <= mat.a22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				cof_s2[k] <= COF_W'(pp_s1[2*k]) - COF_W'(pp_s1[2*k+1]);
			for (int i = 0; i < 3; i++) c2_s2[i] <= c2_s1[i];
		end
	end

	// determinant terms from the last cofactor row and the third column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) cof_s3[k] <= cof_s2[k];
			for (int i = 0; i < 3; i++) trm_s3[i] <= cof_s2[6+i] * c2_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) cof_s4[k] <= cof_s3[k];
			det_s4 <= DET_W'(trm_s3[0]) + DET_W'(trm_s3[1]) + DET_W'(trm_s3[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) cof_s5[k] <= cof_s4[k];
			dmag_s5   <= det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
			dneg_s5   <= det_s4[DET_W-1];
			sing_q[0] <= det_s4 == '0;
			for (int i = 1; i <= SING_D; i++) sing_q[i] <= sing_q[i-1];
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div #(
			.SHIFT(IN_FRAC + OUT_FRAC)
		) u_div (
			.clk (clk),
			.en  (en),
			.cof (cof_s5[k]),
			.dmag(dmag_s5),
			.dneg(dneg_s5),
			.res (res[k]),
			.sat (sat[k])
		);
	end

	assign sing = sing_q[SING_D];

	always_comb begin
		inv.inv00     = sing ? '0 : res[0];
		inv.inv01     = sing ? '0 : res[1];
		inv.inv02     = sing ? '0 : res[2];
		inv.inv10     = sing ? '0 : res[3];
		inv.inv11     = sing ? '0 : res[4];
		inv.inv12     = sing ? '0 : res[5];
		inv.inv20     = sing ? '0 : res[6];
		inv.inv21     = sing ? '0 : res[7];
		inv.inv22     = sing ? '0 : res[8];
		inv.singular  = sing;
		inv.saturated = ~sing & (|sat);
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int LATENCY   = mi3_pkg::OUT_W + 10;
	localparam int N_RANDOM  = 1100;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mi3_pkg::mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	mi3_pkg::inv_t inv;

	mi3_pkg::inv_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;

	typedef struct {
		mi3_pkg::mat_t m;
		bit typed;
		mi3_pkg::inv_t r;
	} row_t;

	matrix_inverse_3x3 i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_valid),
		.mat_stall(mat_stall),
		.mat(mat),
		.inv_valid(inv_valid),
		.inv_stall(inv_stall),
		.inv(inv)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [mi3_pkg::OUT_W-1:0] scale_cofactor(longint cof, longint det,
			ref bit sat);
		logic [127:0] num, d, q, r;
		logic [127:0] lim_pos, lim_neg;
		bit neg;
		num = cof < 0 ? -cof : cof;
		d = det < 0 ? -det : det;
		neg = (cof < 0) != (det < 0);
		if (num == 0)
			return '0;
		num = num << (mi3_pkg::IN_FRAC + mi3_pkg::OUT_FRAC);
		q = num / d;
		r = num % d;
		if (r >= d - r)
			q = q + 1;
		lim_pos = (128'd1 << (mi3_pkg::OUT_W - 1)) - 1;
		lim_neg = 128'd1 << (mi3_pkg::OUT_W - 1);
		if (neg) begin
			if (q > lim_neg) begin
				sat = 1'b1;
				q = lim_neg;
			end
			return -q[mi3_pkg::OUT_W-1:0];
		end
		if (q > lim_pos) begin
			sat = 1'b1;
			q = lim_pos;
		end
		return q[mi3_pkg::OUT_W-1:0];
	endfunction

	function automatic mi3_pkg::inv_t invert_matrix(mi3_pkg::mat_t m);
		longint a00, a01, a02, a10, a11, a12, a20, a21, a22, det;
		longint cof[9];
		logic [mi3_pkg::OUT_W-1:0] e[9];
		bit sat;
		mi3_pkg::inv_t r;
		a00 = m.a00; a01 = m.a01; a02 = m.a02;
		a10 = m.a10; a11 = m.a11; a12 = m.a12;
		a20 = m.a20; a21 = m.a21; a22 = m.a22;
		sat = 1'b0;
		r = '0;
		cof[0] = a11 * a22 - a21 * a12;
		cof[1] = a21 * a02 - a01 * a22;
		cof[2] = a01 * a12 - a11 * a02;
		cof[3] = a12 * a20 - a22 * a10;
		cof[4] = a22 * a00 - a02 * a20;
		cof[5] = a02 * a10 - a12 * a00;
		cof[6] = a10 * a21 - a20 * a11;
		cof[7] = a20 * a01 - a00 * a21;
		cof[8] = a00 * a11 - a10 * a01;
		det = cof[6] * a02 + cof[7] * a12 + cof[8] * a22;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int k = 0; k < 9; k++)
			e[k] = scale_cofactor(cof[k], det, sat);
		r.inv00 = e[0]; r.inv01 = e[1]; r.inv02 = e[2];
		r.inv10 = e[3]; r.inv11 = e[4]; r.inv12 = e[5];
		r.inv20 = e[6]; r.inv21 = e[7]; r.inv22 = e[8];
		r.saturated = sat;
		return r;
	endfunction

	function automatic mi3_pkg::mat_t diag_matrix(logic [mi3_pkg::IN_W-1:0] v);
		mi3_pkg::mat_t m;
		m = '0;
		m.a00 = v;
		m.a11 = v;
		m.a22 = v;
		return m;
	endfunction

	function automatic logic [mi3_pkg::IN_W-1:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3, 4: return 16'($signed($urandom_range(0, 64)) - 32);
			5: return 16'($signed($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mi3_pkg::mat_t rand_matrix();
		mi3_pkg::mat_t m;
		m.a00 = rand_elem(); m.a01 = rand_elem(); m.a02 = rand_elem();
		m.a10 = rand_elem(); m.a11 = rand_elem(); m.a12 = rand_elem();
		m.a20 = rand_elem(); m.a21 = rand_elem(); m.a22 = rand_elem();
		case ($urandom_range(0, 9))
			0: begin
				m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
			end
			1: begin
				m.a01 = m.a00; m.a11 = m.a10; m.a21 = m.a20;
			end
			default: ;
		endcase
		return m;
	endfunction

	task automatic send_matrix(mi3_pkg::mat_t m, bit typed, mi3_pkg::inv_t r);
		while (!quiet && $urandom_range(0, 99) < 18) begin
			mat_valid <= 1'b0;
			@(posedge clk);
		end
		mat_valid <= 1'b1;
		mat <= m;
		expected_q.push_back(typed ? r : invert_matrix(m));
		@(posedge clk);
		while (mat_stall)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("matrix_inverse_3x3: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			inv_stall <= !quiet && ($urandom_range(0, 99) < 18);
		if (arst_n && inv_valid && !inv_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected word %h", inv);
				errors++;
			end else begin
				mi3_pkg::inv_t x;
				x = expected_q.pop_front();
				if (x.inv00 !== inv.inv00) begin
					$error("inv00 exp %h got %h", x.inv00, inv.inv00); errors++;
				end
				if (x.inv01 !== inv.inv01) begin
					$error("inv01 exp %h got %h", x.inv01, inv.inv01); errors++;
				end
				if (x.inv02 !== inv.inv02) begin
					$error("inv02 exp %h got %h", x.inv02, inv.inv02); errors++;
				end
				if (x.inv10 !== inv.inv10) begin
					$error("inv10 exp %h got %h", x.inv10, inv.inv10); errors++;
				end
				if (x.inv11 !== inv.inv11) begin
					$error("inv11 exp %h got %h", x.inv11, inv.inv11); errors++;
				end
				if (x.inv12 !== inv.inv12) begin
					$error("inv12 exp %h got %h", x.inv12, inv.inv12); errors++;
				end
				if (x.inv20 !== inv.inv20) begin
					$error("inv20 exp %h got %h", x.inv20, inv.inv20); errors++;
				end
				if (x.inv21 !== inv.inv21) begin
					$error("inv21 exp %h got %h", x.inv21, inv.inv21); errors++;
				end
				if (x.inv22 !== inv.inv22) begin
					$error("inv22 exp %h got %h", x.inv22, inv.inv22); errors++;
				end
				if (x.singular !== inv.singular) begin
					$error("singular exp %b got %b", x.singular, inv.singular); errors++;
				end
				if (x.saturated !== inv.saturated) begin
					$error("saturated exp %b got %b", x.saturated, inv.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		mi3_pkg::inv_t z;
		mi3_pkg::inv_t ident;
		z = '0;
		ident = '0;
		ident.inv00 = 32'sh10000;
		ident.inv11 = 32'sh10000;
		ident.inv22 = 32'sh10000;

		// zero matrix is singular
		z.singular = 1'b1;
		rw.m = '0; rw.typed = 1'b1; rw.r = z; rows.push_back(rw);
		z.singular = 1'b0;
		rw.m = diag_matrix(16'sh1000); rw.typed = 1'b1; rw.r = ident; rows.push_back(rw);
		rw.typed = 1'b0;
		rw.m = '1;
		rows.push_back(rw);
		rw.m = '0; rw.m.a00 = 16'sh8000; rows.push_back(rw);
		rw.m = diag_matrix(16'sh7fff); rows.push_back(rw);
		rw.m = diag_matrix(16'sh8000); rows.push_back(rw);
		rw.m = diag_matrix(16'sh0001); rows.push_back(rw);
		rw.m = diag_matrix(16'shffff); rows.push_back(rw);
		rw.m = diag_matrix(16'sh0003); rows.push_back(rw);
		rw.m = diag_matrix(16'sh2000); rw.m.a01 = 16'sh8000; rows.push_back(rw);
		rw.m = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh7ffe};
		rows.push_back(rw);
		rw.m = '{16'sh1000, 16'sh2000, 16'sh3000, 16'sh0000, 16'sh1000, 16'sh4000,
			16'sh5000, 16'sh6000, 16'sh0000};
		rows.push_back(rw);
		rw.m = '{16'sh0000, 16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh1000,
			16'sh1000, 16'sh0000, 16'sh0000};
		rows.push_back(rw);
		rw.m = '{16'sh8000, 16'sh7fff, 16'sh0001, 16'sh0001, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh0001, 16'sh8000};
		rows.push_back(rw);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_matrix(rows[i].m, rows[i].typed, rows[i].r);
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet <= (n >= 400 && n < 600);
			send_matrix(rand_matrix(), 1'b0, z);
		end
		mat_valid <= 1'b0;
		quiet <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("matrix_inverse_3x3: match");
		else
			$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

endmodule

FILE: matrix_inverse_3x3.f
sv/mi3_pkg.sv
sv/mi3_div.sv
sv/matrix_inverse_3x3.sv
tb/tb_top.sv
